FILE: hdl/sqipm_pkg.sv
// Shared types and constants for the sorted insert / pop-max queue.
// Used by sqipm_cell and sorted_queue_insert_pop_max_unit; no dependencies.
package sqipm_pkg;

  // payload widths fixed by the item format
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 3;

  // command carried in the input tuser bit
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic insert; // shift-insert the new value into the sorted row
    logic load;   // copy the post-operation row into the dump chain
    logic shift;  // move the dump chain one place toward cell 0
  } cell_ctl_t;

endpackage

FILE: hdl/sqipm_cell.sv
// One cell of the sorted row: a stored value plus one stage of the dump chain.
// Depends on sqipm_pkg for the value width and the control struct.
module sqipm_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                              clk,
  input  sqipm_pkg::cell_ctl_t              ctl,
  input  logic [CNT_W-1:0]                  count,
  input  logic signed [sqipm_pkg::VALUE_W-1:0] new_value,
  input  logic                              left_take,
  input  logic signed [sqipm_pkg::VALUE_W-1:0] left_value,
  input  logic [sqipm_pkg::VALUE_W-1:0]     right_dump,
  output logic                              take,
  output logic signed [sqipm_pkg::VALUE_W-1:0] value,
  output logic [sqipm_pkg::VALUE_W-1:0]     dump
);
  import sqipm_pkg::*;

  logic                      occupied;
  logic                      greater;
  logic                      at_end;
  logic signed [VALUE_W-1:0] value_next;
  logic [VALUE_W-1:0]        dump_next;

  // this cell is at or past the insert point: it holds a larger value,
  // or it is the first free slot
  assign occupied = CNT_W'(INDEX) < count;
  assign greater  = occupied && (value > new_value);
  assign at_end   = count == CNT_W'(INDEX);
  assign take     = greater || at_end;

  // left neighbor past the insert point: shift up; here: take new value
  always_comb begin
    value_next = value;
    if (ctl.insert) begin
      if (left_take) begin
        value_next = left_value;
      end else if (take) begin
        value_next = new_value;
      end
    end
  end

  // dump stage loads the updated row, then streams toward cell 0
  always_comb begin
    dump_next = dump;
    if (ctl.load) begin
      dump_next = value_next;
    end else if (ctl.shift) begin
      dump_next = right_dump;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    dump  <= dump_next;
  end

endmodule

FILE: hdl/sorted_queue_insert_pop_max_unit.sv
// Sorted insert / pop-max queue: top level with fill count, flags and output word.
// Depends on sqipm_pkg and instantiates a row of DEPTH sqipm_cell cells.
//
// Keeps up to DEPTH signed 32-bit values in ascending order in a row of cells.
// A command word is applied to the row as it is taken: insert places the value after
// every stored value not larger than it (all cells compare in parallel and the
// larger ones shift up one place), remove drops the largest value by lowering the
// fill count. The updated row is copied into a dump chain in the same edge and then
// streamed out from cell 0, one word per cycle while m_tready does not stall the
// output, max(count,1) words per command; an empty store gives one word with
// entry_valid low. The next command is taken in the cycle after the last word of
// the dump has left the chain, later if m_tready is held low. The output register
// can still hold that last word while the next command enters.
module sorted_queue_insert_pop_max_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sqipm_pkg::S_TDATA_W-1:0]     s_tdata,  // [31:0] value
  input  logic                                s_tuser,  // [0] cmd
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sqipm_pkg::M_TDATA_W-1:0]     m_tdata,  // [4:0] count, [36:5] entry, zero pad
  output logic [sqipm_pkg::M_TUSER_W-1:0]     m_tuser,  // [0] entry_valid, [1] nothing_to_delete, [2] overflow
  output logic                                m_tlast
);
  import sqipm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                      accept;
  logic                      out_load;
  cmd_t                      cmd;
  logic signed [VALUE_W-1:0] new_value;
  logic                      full;
  logic                      empty;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          cnt_next;
  logic [CNT_W-1:0]          remaining;
  logic [CNT_W-1:0]          op_count;
  logic                      op_nothing;
  logic                      op_ovf;
  cell_ctl_t                 ctl;

  logic                      take  [DEPTH];
  logic signed [VALUE_W-1:0] value [DEPTH];
  logic [VALUE_W-1:0]        dump  [DEPTH];

  assign cmd       = cmd_t'(s_tuser);
  assign new_value = $signed(s_tdata[VALUE_W-1:0]);
  assign s_tready  = remaining == '0;
  assign accept    = s_tvalid && s_tready;
  assign out_load  = (remaining != '0) && (!m_tvalid || m_tready);
  assign full      = cnt == CNT_W'(DEPTH);
  assign empty     = cnt == '0;

  // new fill count after the command
  always_comb begin
    cnt_next = cnt;
    unique case (cmd)
      CMD_INSERT: if (!full) cnt_next = cnt + 1'b1;
      CMD_REMOVE: if (!empty) cnt_next = cnt - 1'b1;
      default:    cnt_next = cnt;
    endcase
  end

  assign ctl.insert = accept && (cmd == CMD_INSERT) && !full;
  assign ctl.load   = accept;
  assign ctl.shift  = out_load;

  // row of cells, dump chain flows toward cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sqipm_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (cnt),
      .new_value  (new_value),
      .left_take  ((i == 0) ? 1'b0 : take[(i == 0) ? 0 : i - 1]),
      .left_value ((i == 0) ? '0 : value[(i == 0) ? 0 : i - 1]),
      .right_dump ((i == DEPTH - 1) ? '0 : dump[(i == DEPTH - 1) ? i : i + 1]),
      .take       (take[i]),
      .value      (value[i]),
      .dump       (dump[i])
    );
  end

  // fill count, dump length and per-command flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      remaining <= '0;
    end else if (accept) begin
      cnt       <= cnt_next;
      remaining <= (cnt_next == '0) ? CNT_W'(1) : cnt_next;
    end else if (out_load) begin
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_count   <= cnt_next;
      op_nothing <= (cmd == CMD_REMOVE) && empty;
      op_ovf     <= (cmd == CMD_INSERT) && full;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(M_TDATA_W - VALUE_W - COUNT_W)'(0),
                  (op_count == '0) ? '0 : dump[0],
                  COUNT_W'(op_count)};
      m_tuser <= {op_ovf, op_nothing, op_count != '0};
      m_tlast <= remaining == CNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the row length
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // a taken command always starts a dump and blocks the input
  a_accept_dump: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready && (remaining != '0))
    else $error("command taken without a dump");

  // an empty-store word is the only and final word, with count zero
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata[COUNT_W-1:0] == '0)))
    else $error("empty word not alone");

  // dropped insert only when the row is full
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tdata[COUNT_W-1:0] == COUNT_W'(DEPTH)))
    else $error("overflow flag below full");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for sorted_queue_insert_pop_max_unit: directed and random
// insert / remove commands, each dump word checked against a local sorted-store predictor.
// Depends on sqipm_pkg and the unit RTL only.
module tb;
  import sqipm_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;
  localparam int PRINT_CAP   = 40;
  localparam int RANDOM_OPS  = 180;

  // one expected dump word
  typedef struct {
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] entry;
    logic                      entry_valid;
    logic                      last;
    logic                      nothing_to_delete;
    logic                      overflow;
  } dump_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // [31:0] value
  logic                 s_tuser = 1'b0; // [0] cmd
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;  // [4:0] count, [36:5] entry, zero pad
  logic [M_TUSER_W-1:0] m_tuser;  // [0] entry_valid, [1] nothing_to_delete, [2] overflow
  logic                 m_tlast;

  // predictor state and pending dump words
  logic signed [VALUE_W-1:0] store_vals [DEPTH];
  int                        store_fill = 0;
  dump_word_t                dump_due [$];

  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          src_gaps = 1'b0;
  bit          sink_stalls = 1'b0;
  int          stall_left = 0;

  sorted_queue_insert_pop_max_unit #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // apply one command to the sorted store and queue the dump it produces
  function automatic void apply_queue_op(input cmd_t cmd, input logic signed [VALUE_W-1:0] value);
    dump_word_t w;
    logic       nothing;
    logic       ovf;
    int         pos;
    nothing = 1'b0;
    ovf     = 1'b0;
    if (cmd == CMD_REMOVE) begin
      if (store_fill == 0) nothing = 1'b1;
      else store_fill--;
    end else if (store_fill >= DEPTH) begin
      ovf = 1'b1;
    end else begin
      // equal values keep arrival order: go past every entry not larger
      pos = 0;
      while (pos < store_fill && store_vals[pos] <= value) pos++;
      for (int i = store_fill; i > pos; i--) store_vals[i] = store_vals[i - 1];
      store_vals[pos] = value;
      store_fill++;
    end
    w.nothing_to_delete = nothing;
    w.overflow          = ovf;
    if (store_fill == 0) begin
      w.count       = '0;
      w.entry       = '0;
      w.entry_valid = 1'b0;
      w.last        = 1'b1;
      dump_due.push_back(w);
    end else begin
      for (int k = 0; k < store_fill; k++) begin
        w.count       = COUNT_W'(store_fill);
        w.entry       = store_vals[k];
        w.entry_valid = 1'b1;
        w.last        = (k == store_fill - 1);
        dump_due.push_back(w);
      end
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink side: random back-pressure and word checks
  always @(posedge clk) begin
    dump_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 99) < 25) stall_left = pick_gap(1'b1) + 1;
      end
      if (m_tvalid && m_tready) begin
        if (dump_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word count=%0d entry=%0d",
                                    m_tdata[4:0], $signed(m_tdata[36:5])));
        end else begin
          want = dump_due.pop_front();
          if (m_tdata[4:0] !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", m_tdata[4:0], want.count));
          if (m_tdata[36:5] !== want.entry)
            report_mismatch($sformatf("entry got %0d want %0d",
                                      $signed(m_tdata[36:5]), want.entry));
          if (m_tuser[0] !== want.entry_valid)
            report_mismatch($sformatf("entry_valid got %b want %b", m_tuser[0],
                                      want.entry_valid));
          if (m_tuser[1] !== want.nothing_to_delete)
            report_mismatch($sformatf("nothing_to_delete got %b want %b", m_tuser[1],
                                      want.nothing_to_delete));
          if (m_tuser[2] !== want.overflow)
            report_mismatch($sformatf("overflow got %b want %b", m_tuser[2], want.overflow));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("tlast got %b want %b", m_tlast, want.last));
        end
      end
    end
  end

  // send one command word; valid stays high between back-to-back words
  task automatic send_cmd(input cmd_t cmd, input logic signed [VALUE_W-1:0] value);
    int gap;
    gap = pick_gap(src_gaps);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    apply_queue_op(cmd, value);
  endtask

  // stop sending until every expected word has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (dump_due.size() != 0);
  endtask

  // remove on an empty store
  task automatic test_empty_remove();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    send_cmd(CMD_REMOVE, 32'sd0);
    send_cmd(CMD_REMOVE, 32'sd7);
    send_cmd(CMD_REMOVE, -32'sd2);
    wait_drained();
  endtask

  // fill to the top with extremes and repeats, then insert into a full store
  task automatic test_fill_overflow();
    logic signed [VALUE_W-1:0] fill_vals [DEPTH];
    fill_vals = '{32'sd5, -32'sd2, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 32'sd5,
                  -32'sd1, 32'sd3, -32'sd2, 32'sd100, -32'sd100, 32'sd5, 32'sd1,
                  32'sd2, 32'sh7FFF_FFFF, 32'sh8000_0000};
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    for (int n = 0; n < DEPTH; n++) send_cmd(CMD_INSERT, fill_vals[n]);
    send_cmd(CMD_INSERT, 32'sd9);
    send_cmd(CMD_INSERT, -32'sd2);
    send_cmd(CMD_INSERT, 32'sd0);
    wait_drained();
  endtask

  // remove everything and one more, under gaps and back-pressure
  task automatic test_drain();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    for (int n = 0; n <= DEPTH; n++) send_cmd(CMD_REMOVE, 32'sd0);
    wait_drained();
  endtask

  // repeated values and minus two as an ordinary value
  task automatic test_equal_values();
    src_gaps    = 1'b0;
    sink_stalls = 1'b1;
    send_cmd(CMD_INSERT, -32'sd2);
    send_cmd(CMD_INSERT, -32'sd2);
    send_cmd(CMD_INSERT, -32'sd2);
    send_cmd(CMD_INSERT, -32'sd2);
    send_cmd(CMD_INSERT, 32'sd7);
    send_cmd(CMD_INSERT, -32'sd2);
    send_cmd(CMD_INSERT, 32'sd7);
    send_cmd(CMD_REMOVE, -32'sd2);
    send_cmd(CMD_INSERT, -32'sd3);
    send_cmd(CMD_REMOVE, 32'sd0);
    send_cmd(CMD_REMOVE, 32'sd0);
    send_cmd(CMD_INSERT, -32'sd2);
    wait_drained();
  endtask

  // random mix that swings the store between full and empty
  task automatic test_random();
    cmd_t                      cmd;
    logic signed [VALUE_W-1:0] v;
    int                        ins_pct;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      ins_pct = (n < 60 || (n >= 120 && n < 150)) ? 75 : 30;
      cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
      if ($urandom_range(0, 1) == 0) v = VALUE_W'(int'($urandom_range(0, 8)) - 4);
      else v = $urandom();
      send_cmd(cmd, v);
      if (n == RANDOM_OPS / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_remove();
    test_fill_overflow();
    test_drain();
    test_equal_values();
    test_random();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && dump_due.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
